// ===== design/mwsl_pkg.sv =====
// ----------------------------------------------------------------------------
// mwsl_pkg
// Shared widths, types and defaults for the limited-flag window sum block.
// ----------------------------------------------------------------------------
package mwsl_pkg;

	localparam int SUM_W = 32;
	localparam int VAL_W = 16;
	localparam int LIM_W = 4;
	localparam int LIMIT_RANGE = 2 ** LIM_W;
	localparam int BOUNDARY_DEPTH_DEF = 16;

	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [VAL_W-1:0] val_t;
	typedef logic [LIM_W-1:0] lim_t;

	// control broadcast to every boundary cell
	typedef struct packed {
		logic shift;
		lim_t tap_idx;
	} cell_ctl_t;

endpackage

// ===== design/mwsl_cell.sv =====
// ----------------------------------------------------------------------------
// mwsl_cell
// One boundary cell: holds the running total at one past risky unit, shifts
// toward the older end on each risky unit and ORs its value onto the tap
// chain when it is the selected entry.
// ----------------------------------------------------------------------------
module mwsl_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mwsl_pkg::cell_ctl_t ctl,
	input  mwsl_pkg::sum_t    shift_in,
	output mwsl_pkg::sum_t    shift_out,
	input  mwsl_pkg::sum_t    tap_in,
	output mwsl_pkg::sum_t    tap_out
);
	import mwsl_pkg::*;

	localparam lim_t IDX_L = lim_t'(CELL_IDX % LIMIT_RANGE);

	sum_t value_q;
	logic hit;

	// shift in the neighbor's boundary on a risky unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (ctl.shift) begin
			value_q <= shift_in;
		end
	end

	// put this entry on the tap chain when it is the one selected
	assign hit       = (CELL_IDX < LIMIT_RANGE) && (ctl.tap_idx == IDX_L);
	assign tap_out   = tap_in | (hit ? value_q : '0);
	assign shift_out = value_q;

endmodule

// ===== design/max_window_sum_limited_flags.sv =====
// ----------------------------------------------------------------------------
// max_window_sum_limited_flags
// Best contiguous window sum holding at most risk_limit risky units.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries is_risky and unit_value; a
//   transaction completes when in_valid is high and in_stall is low.
//   Output channel (out_valid / out_stall) returns one best_sum per input
//   unit, in order; the receiver holds out_stall to back-pressure.
//   Config channel (cfg_valid / cfg_ready) writes risk_limit; cfg_ready is
//   always high. Write it only while no unit is in flight.
// Path: an input transaction is registered in stages 1, 2 and 3 before out_valid.
// Throughput: one unit per cycle unless out_stall backs up all stages. The loop
//   that sets it is the saturating running-total add and the boundary cell shift.
// Stall: a result waiting under out_stall does not block intake until all
//   three stages hold data; in_stall then rises the same cycle.
// Reset: running total, boundary cells, risky count, best sum and risk_limit
//   clear to zero; all stages empty.
// ----------------------------------------------------------------------------
module max_window_sum_limited_flags #(
	parameter int BOUNDARY_DEPTH = mwsl_pkg::BOUNDARY_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           is_risky,
	input  mwsl_pkg::val_t unit_value,
	output logic           out_valid,
	input  logic           out_stall,
	output mwsl_pkg::sum_t best_sum,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  mwsl_pkg::lim_t cfg_data
);
	import mwsl_pkg::*;

	localparam int SEEN_W = $clog2(BOUNDARY_DEPTH + 1);

	// architectural state
	sum_t              rt_q;
	logic [SEEN_W-1:0] seen_q;
	lim_t              limit_q;
	sum_t              best_q;

	// pipeline
	logic v_s1, v_s2, v_s3;
	sum_t rt_s1, base_s1, window_s2;

	// handshake chain
	logic out_free, free2, free1, accept, load2, load3;

	// front-end combinational values
	logic [SUM_W:0]    sum_ext;
	sum_t              rt_new;
	logic [SEEN_W-1:0] seen_new;
	logic              use_base;
	sum_t              base_sel;
	cell_ctl_t         ctl;

	// cell chain wiring
	sum_t shift_bus [BOUNDARY_DEPTH+1];
	sum_t tap_bus   [BOUNDARY_DEPTH+1];

	// advance when the next stage is free
	assign out_free = !v_s3 || !out_stall;
	assign load3    = v_s2 && out_free;
	assign free2    = !v_s2 || out_free;
	assign load2    = v_s1 && free2;
	assign free1    = !v_s1 || free2;
	assign accept   = in_valid && free1;
	assign in_stall = !free1;

	assign cfg_ready = 1'b1;

	// config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// saturating running total
	assign sum_ext = {1'b0, rt_q} + (SUM_W+1)'(unit_value);
	assign rt_new  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

	assign seen_new = (is_risky && (int'(seen_q) < BOUNDARY_DEPTH)) ?
		seen_q + SEEN_W'(1) : seen_q;

	// pick the entry that becomes index risk_limit after this unit
	assign ctl.shift   = accept && is_risky;
	assign ctl.tap_idx = is_risky ? limit_q - lim_t'(1) : limit_q;

	assign shift_bus[0] = rt_new;
	assign tap_bus[0]   = '0;

	for (genvar k = 0; k < BOUNDARY_DEPTH; k++) begin : g_cell
		mwsl_cell #(
			.CELL_IDX(k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.shift_in (shift_bus[k]),
			.shift_out(shift_bus[k+1]),
			.tap_in   (tap_bus[k]),
			.tap_out  (tap_bus[k+1])
		);
	end

	assign use_base = (int'(limit_q) < BOUNDARY_DEPTH) && (int'(seen_new) > int'(limit_q));
	assign base_sel = (is_risky && (limit_q == '0)) ? rt_new : tap_bus[BOUNDARY_DEPTH];

	// update state on an input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_q   <= '0;
			seen_q <= '0;
		end else if (accept) begin
			rt_q   <= rt_new;
			seen_q <= seen_new;
		end
	end

	// stage 1: total and window base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (free1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rt_s1   <= rt_new;
			base_s1 <= use_base ? base_sel : '0;
		end
	end

	// stage 2: window sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (free2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load2) begin
			window_s2 <= rt_s1 - base_s1;
		end
	end

	// stage 3: fold into best and hold for the receiver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3   <= 1'b0;
			best_q <= '0;
		end else begin
			if (out_free) begin
				v_s3 <= v_s2;
			end
			if (load3 && (window_s2 > best_q)) begin
				best_q <= window_s2;
			end
		end
	end

	assign out_valid = v_s3;
	assign best_sum  = best_q;

	// checks
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && out_stall))
		else $error("input stalled with a free stage");

	a_best_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (best_q >= $past(best_q)))
		else $error("best sum decreased");

	a_base_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (base_s1 <= rt_s1))
		else $error("window base above running total");

	a_best_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && out_stall) |=> $stable(best_q))
		else $error("best sum changed under output stall");

endmodule
